// ===== src/so3_exponential_map_core_defines.svh =====
// ----------------------------------------------------------------------------
// so3_exponential_map_core_defines.svh
// Assertion macros shared by the SO(3) exponential map RTL.
// ----------------------------------------------------------------------------
`ifndef SO3_EXPONENTIAL_MAP_CORE_DEFINES_SVH
`define SO3_EXPONENTIAL_MAP_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// clocked assertion, masked while reset is high
`define SO3EM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked assertion that also holds through reset
`define SO3EM_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SO3EM_ASSERT(lbl, clk, rst, prop, msg)
`define SO3EM_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== src/so3em_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// so3em_pkg
// Shared constants, types and fixed-point helpers of the SO(3) exp map core.
// ----------------------------------------------------------------------------
package so3em_pkg;

  localparam int unsigned SQRT_LAT = 32;
  localparam int unsigned TERMS    = 8;
  localparam int unsigned TRIG_LAT = 4 * TERMS + 3;
  localparam int unsigned DIV_LAT  = 31;
  localparam int unsigned PAD_LAT  = TRIG_LAT - DIV_LAT;

  localparam logic [31:0] TURN_SCALE = 32'd2734261102;  // round(2^33 / pi)
  localparam logic [31:0] PI_Q30     = 32'd3373259426;  // round(pi * 2^30)

  // Q1.30 with headroom for +-2^31
  typedef logic signed [32:0] q30_t;

  localparam q30_t ONE_Q30 = 33'sd1073741824;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
  } side_t;

  typedef struct packed {
    logic [2:0][32:0] rem;
    logic [2:0][30:0] quo;
    logic [2:0]       neg;
    logic [31:0]      a;
  } div_t;

  typedef struct packed {
    quad_t              quad;
    logic [30:0]        x;
    logic [31:0]        ts;
    logic [31:0]        tc;
    logic signed [33:0] ss;
    logic signed [33:0] cc;
    logic [31:0]        ns;
    logic [31:0]        nc;
    logic [63:0]        ms;
    logic [63:0]        mc;
  } tay_t;

  // Q1.30 product, truncated toward zero
  function automatic q30_t mulq(input q30_t a, input q30_t b);
    q30_t        na;
    q30_t        nb;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] p;
    q30_t        m;
    na = -a;
    nb = -b;
    ma = a[32] ? na[31:0] : a[31:0];
    mb = b[32] ? nb[31:0] : b[31:0];
    p  = {32'd0, ma} * {32'd0, mb};
    m  = $signed({1'b0, p[61:30]});
    return (a[32] ^ b[32]) ? -m : m;
  endfunction

  function automatic logic [31:0] sat_q30(input logic signed [34:0] v);
    logic [31:0] r;
    if (v > 35'sd1073741824) begin
      r = 32'h4000_0000;
    end else if (v < -35'sd1073741824) begin
      r = 32'hC000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== src/so3em_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// so3em_isqrt
// Pipelined floor square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module so3em_isqrt
  import so3em_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] sum_sq,
  output logic [31:0] root
);

  logic [63:0] rem [SQRT_LAT];
  logic [63:0] res [SQRT_LAT];

  for (genvar g = 0; g < SQRT_LAT; g++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
    logic [63:0] n_in;
    logic [63:0] r_in;
    logic [63:0] trial;

    if (g == 0) begin : g_first
      assign n_in = sum_sq;
      assign r_in = '0;
    end else begin : g_rest
      assign n_in = rem[g-1];
      assign r_in = res[g-1];
    end

    assign trial = r_in + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (n_in >= trial) begin
          rem[g] <= n_in - trial;
          res[g] <= (r_in >> 1) + BIT;
        end else begin
          rem[g] <= n_in;
          res[g] <= r_in >> 1;
        end
      end
    end
  end

  assign root = res[SQRT_LAT-1][31:0];

endmodule

// ===== src/so3em_sincos.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// so3em_sincos
// Pipelined sine and cosine of a Q4.27 angle: phase wrap, quadrant split and
// a Taylor series evaluated four stages per term pair.
// ----------------------------------------------------------------------------
module so3em_sincos
  import so3em_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] angle,
  output q30_t        sin_val,
  output q30_t        cos_val
);

  logic [63:0] ph_prod;
  quad_t       quad_p;
  logic [29:0] frac_p;
  logic [63:0] x_prod;
  quad_t       quad_x;
  logic [30:0] x0;
  tay_t        tay_init;
  tay_t        tay [4*TERMS];

  // phase in turns: bits [60:29] of the product, top two bits the quadrant
  assign ph_prod = {32'd0, angle} * {32'd0, TURN_SCALE};

  always_ff @(posedge clk) begin
    if (en) begin
      quad_p <= quad_t'(ph_prod[60:59]);
      frac_p <= ph_prod[58:29];
    end
  end

  assign x_prod = {34'd0, frac_p} * {32'd0, PI_Q30};

  always_ff @(posedge clk) begin
    if (en) begin
      quad_x <= quad_p;
      x0     <= x_prod[61:31];
    end
  end

  always_comb begin
    tay_init      = '0;
    tay_init.quad = quad_x;
    tay_init.x    = x0;
    tay_init.ts   = {1'b0, x0};
    tay_init.tc   = 32'h4000_0000;
    tay_init.ss   = $signed({3'b000, x0});
    tay_init.cc   = 34'sd1073741824;
  end

  // per term: t*x, then *x, then reciprocal multiply, then correct and add
  for (genvar g = 0; g < 4 * TERMS; g++) begin : g_tay
    localparam int unsigned K  = g / 4 + 1;
    localparam int unsigned PH = g % 4;
    localparam logic [31:0] DS = 32'((2 * K) * (2 * K + 1));
    localparam logic [31:0] DC = 32'((2 * K - 1) * (2 * K));
    localparam logic [31:0] MS = 32'((64'd1 << 32) / DS);
    localparam logic [31:0] MC = 32'((64'd1 << 32) / DC);

    tay_t cur;
    tay_t nxt;

    if (g == 0) begin : g_first
      assign cur = tay_init;
    end else begin : g_rest
      assign cur = tay[g-1];
    end

    if (PH == 0) begin : g_mul_a
      logic [63:0] ps;
      logic [63:0] pc;
      always_comb begin
        ps     = {32'd0, cur.ts} * {33'd0, cur.x};
        pc     = {32'd0, cur.tc} * {33'd0, cur.x};
        nxt    = cur;
        nxt.ns = ps[61:30];
        nxt.nc = pc[61:30];
      end
    end else if (PH == 1) begin : g_mul_b
      logic [63:0] ps;
      logic [63:0] pc;
      always_comb begin
        ps     = {32'd0, cur.ns} * {33'd0, cur.x};
        pc     = {32'd0, cur.nc} * {33'd0, cur.x};
        nxt    = cur;
        nxt.ns = ps[61:30];
        nxt.nc = pc[61:30];
      end
    end else if (PH == 2) begin : g_recip
      always_comb begin
        nxt    = cur;
        nxt.ms = {32'd0, cur.ns} * {32'd0, MS};
        nxt.mc = {32'd0, cur.nc} * {32'd0, MC};
      end
    end else begin : g_fix
      logic [31:0] qs;
      logic [31:0] qc;
      logic [35:0] rs;
      logic [35:0] rc;
      always_comb begin
        qs  = cur.ms[63:32];
        qc  = cur.mc[63:32];
        // reciprocal estimate is at most one low
        rs  = {4'd0, cur.ns} - ({4'd0, qs} * {4'd0, DS});
        rc  = {4'd0, cur.nc} - ({4'd0, qc} * {4'd0, DC});
        if (rs >= {4'd0, DS}) begin
          qs = qs + 32'd1;
        end
        if (rc >= {4'd0, DC}) begin
          qc = qc + 32'd1;
        end
        nxt    = cur;
        nxt.ts = qs;
        nxt.tc = qc;
        if (K % 2 == 1) begin
          nxt.ss = cur.ss - $signed({2'b00, qs});
          nxt.cc = cur.cc - $signed({2'b00, qc});
        end else begin
          nxt.ss = cur.ss + $signed({2'b00, qs});
          nxt.cc = cur.cc + $signed({2'b00, qc});
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tay[g] <= nxt;
      end
    end
  end

  tay_t last;
  q30_t s_cl;
  q30_t c_cl;

  assign last = tay[4*TERMS-1];

  always_comb begin
    if (last.ss < 34'sd0) begin
      s_cl = '0;
    end else if (last.ss > 34'sd1073741824) begin
      s_cl = ONE_Q30;
    end else begin
      s_cl = $signed({2'b00, last.ss[30:0]});
    end
    if (last.cc < 34'sd0) begin
      c_cl = '0;
    end else if (last.cc > 34'sd1073741824) begin
      c_cl = ONE_Q30;
    end else begin
      c_cl = $signed({2'b00, last.cc[30:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (last.quad)
        QUAD_0: begin
          sin_val <= s_cl;
          cos_val <= c_cl;
        end
        QUAD_1: begin
          sin_val <= c_cl;
          cos_val <= -s_cl;
        end
        QUAD_2: begin
          sin_val <= -s_cl;
          cos_val <= -c_cl;
        end
        default: begin
          sin_val <= -c_cl;
          cos_val <= s_cl;
        end
      endcase
    end
  end

endmodule

// ===== src/so3_exponential_map_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// so3_exponential_map_core
// Rotation vector (Q4.27) to 3x3 rotation matrix (Q1.30) by Rodrigues' formula.
// ----------------------------------------------------------------------------
// Fully pipelined: one rotation vector per clock while results are taken
// (3 input/square/sum stages, 32 square-root stages, 35 stages for the
// axis division and delay beside sine/cosine, 3 matrix stages). When the output
// beat is not taken the whole pipeline holds, so s_tready follows m_tready
// whenever a result is pending. A zero vector returns the identity matrix.
module so3_exponential_map_core
  import so3em_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // rot_x, rot_y, rot_z
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [287:0] m_tdata    // m00, m01, m02, m10, m11, m12, m20, m21, m22
);

`include "so3_exponential_map_core_defines.svh"

  localparam int unsigned LAT = 3 + SQRT_LAT + TRIG_LAT + 3;

  logic [LAT-1:0] vld;
  logic           adv;

  assign adv      = !vld[LAT-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // magnitudes and squares
  side_t       in_side;
  side_t       side0;
  side_t       side1;
  side_t       side2;
  logic [63:0] sq1 [3];
  logic [63:0] sum2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_side.neg[i] = s_tdata[32*i+31];
      in_side.mag[i] = s_tdata[32*i+31] ? (32'd0 - s_tdata[32*i +: 32])
                                        : s_tdata[32*i +: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side0 <= in_side;
      side1 <= side0;
      side2 <= side1;
      for (int i = 0; i < 3; i++) begin
        sq1[i] <= {32'd0, side0.mag[i]} * {32'd0, side0.mag[i]};
      end
      sum2 <= sq1[0] + sq1[1] + sq1[2];
    end
  end

  logic [31:0] root;

  so3em_isqrt u_isqrt (
    .clk    (clk),
    .en     (adv),
    .sum_sq (sum2),
    .root   (root)
  );

  side_t sd [SQRT_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0] <= side2;
      for (int g = 1; g < SQRT_LAT; g++) begin
        sd[g] <= sd[g-1];
      end
    end
  end

  q30_t sin_val;
  q30_t cos_val;

  so3em_sincos u_sincos (
    .clk     (clk),
    .en      (adv),
    .angle   (root),
    .sin_val (sin_val),
    .cos_val (cos_val)
  );

  // axis: |v| * 2^30 / a, restoring division one quotient bit per stage
  div_t dv [DIV_LAT];

  for (genvar g = 0; g < DIV_LAT; g++) begin : g_div
    localparam int unsigned QB = DIV_LAT - 1 - g;
    div_t cur;
    div_t nxt;

    if (g == 0) begin : g_first
      always_comb begin
        cur     = '0;
        cur.neg = sd[SQRT_LAT-1].neg;
        cur.a   = root;
        for (int i = 0; i < 3; i++) begin
          cur.rem[i] = {1'b0, sd[SQRT_LAT-1].mag[i]};
        end
      end
    end else begin : g_rest
      assign cur = dv[g-1];
    end

    always_comb begin
      logic [32:0] t;
      nxt = cur;
      for (int i = 0; i < 3; i++) begin
        t = (g == 0) ? cur.rem[i] : {cur.rem[i][31:0], 1'b0};
        if (t >= {1'b0, cur.a}) begin
          nxt.rem[i]     = t - {1'b0, cur.a};
          nxt.quo[i][QB] = 1'b1;
        end else begin
          nxt.rem[i] = t;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv[g] <= nxt;
      end
    end
  end

  // signed axis, delayed to line up with sine/cosine
  q30_t u_new [3];
  q30_t pd [PAD_LAT][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv[DIV_LAT-1].a == 32'd0) begin
        u_new[i] = '0;
      end else if (dv[DIV_LAT-1].neg[i]) begin
        u_new[i] = -$signed({2'b00, dv[DIV_LAT-1].quo[i]});
      end else begin
        u_new[i] = $signed({2'b00, dv[DIV_LAT-1].quo[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pd[0] <= u_new;
      for (int g = 1; g < PAD_LAT; g++) begin
        pd[g] <= pd[g-1];
      end
    end
  end

  // matrix: uu = u_i*u_j (00 01 02 11 12 22), su = sin*u_k, w = 1 - cos
  q30_t uu1 [6];
  q30_t su1 [3];
  q30_t w1;
  q30_t cs1;
  q30_t wuu2 [6];
  q30_t su2 [3];
  q30_t cs2;

  always_ff @(posedge clk) begin
    if (adv) begin
      uu1[0] <= mulq(pd[PAD_LAT-1][0], pd[PAD_LAT-1][0]);
      uu1[1] <= mulq(pd[PAD_LAT-1][0], pd[PAD_LAT-1][1]);
      uu1[2] <= mulq(pd[PAD_LAT-1][0], pd[PAD_LAT-1][2]);
      uu1[3] <= mulq(pd[PAD_LAT-1][1], pd[PAD_LAT-1][1]);
      uu1[4] <= mulq(pd[PAD_LAT-1][1], pd[PAD_LAT-1][2]);
      uu1[5] <= mulq(pd[PAD_LAT-1][2], pd[PAD_LAT-1][2]);
      for (int k = 0; k < 3; k++) begin
        su1[k] <= mulq(sin_val, pd[PAD_LAT-1][k]);
      end
      w1  <= ONE_Q30 - cos_val;
      cs1 <= cos_val;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int p = 0; p < 6; p++) begin
        wuu2[p] <= mulq(w1, uu1[p]);
      end
      su2 <= su1;
      cs2 <= cs1;
    end
  end

  logic signed [34:0] ent [9];

  // skew term: K = [u]x, so sin*K_ij is +-su of the third axis
  always_comb begin
    ent[0] = 35'(cs2) + 35'(wuu2[0]);
    ent[1] = 35'(wuu2[1]) - 35'(su2[2]);
    ent[2] = 35'(wuu2[2]) + 35'(su2[1]);
    ent[3] = 35'(wuu2[1]) + 35'(su2[2]);
    ent[4] = 35'(cs2) + 35'(wuu2[3]);
    ent[5] = 35'(wuu2[4]) - 35'(su2[0]);
    ent[6] = 35'(wuu2[2]) - 35'(su2[1]);
    ent[7] = 35'(wuu2[4]) + 35'(su2[0]);
    ent[8] = 35'(cs2) + 35'(wuu2[5]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < 9; e++) begin
        m_tdata[32*e +: 32] <= sat_q30(ent[e]);
      end
    end
  end

  `SO3EM_ASSERT_NR(a_rst_clears_out, clk, rst |=> !m_tvalid, "output valid after reset")
  `SO3EM_ASSERT(a_stall_blocks_in, clk, rst, (m_tvalid && !m_tready) |-> !s_tready,
                "input taken while output stalled")
  `SO3EM_ASSERT(a_accept_enters, clk, rst, (s_tvalid && s_tready) |=> vld[0],
                "accepted beat missing from first stage")
  `SO3EM_ASSERT(a_m00_range, clk, rst,
                m_tvalid |-> ($signed(m_tdata[31:0]) <= 32'sd1073741824 &&
                              $signed(m_tdata[31:0]) >= -32'sd1073741824),
                "m00 outside unit range")

endmodule

// ===== bench/so3_exponential_map_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// so3_exponential_map_core_tb
// Drives random and corner rotation vectors into the SO(3) exp map core and
// compares every output matrix beat against a bit-true fixed-point predictor.
// ----------------------------------------------------------------------------

class rot_matrix_board;
  logic [287:0] pending_q[$];
  int           errors;

  function new();
    errors = 0;
  endfunction

  static function logic [63:0] mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  static function longint mul30(input longint a, input longint b);
    logic [63:0] p;
    p = (mag(a) * mag(b)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  static function longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Rodrigues rotation of one Q4.27 vector into a packed Q1.30 matrix
  static function logic [287:0] rodrigues(input logic [95:0] vec);
    longint       v[3], u[3], kx[3][3];
    logic [63:0]  sumsq, ang, rem, res, bit_w, phase, rfrac, x, ts, tc, m;
    longint       ss, cc, sq, cq, sn, cs, w, e;
    logic [1:0]   quad;
    logic [287:0] mat;
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      v[i] = longint'($signed(vec[32*i +: 32]));
      sumsq += mag(v[i]) * mag(v[i]);
    end
    // integer square root
    rem = sumsq; res = 0; bit_w = 64'd1 << 62;
    while (bit_w > rem) bit_w >>= 2;
    while (bit_w != 0) begin
      if (rem >= res + bit_w) begin
        rem -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    ang = res;
    for (int i = 0; i < 3; i++) begin
      if (ang == 0) begin
        u[i] = 0;
      end else begin
        m = (mag(v[i]) << 30) / ang;
        u[i] = (v[i] < 0) ? -longint'(m) : longint'(m);
      end
    end
    phase = ((ang * 64'd2734261102) >> 29) & 64'hFFFF_FFFF;
    quad  = phase[31:30];
    rfrac = phase & 64'h3FFF_FFFF;
    x     = (rfrac * 64'd3373259426) >> 31;
    ts = x; tc = 64'd1 << 30; ss = x; cc = 1 << 30;
    for (int k = 1; k <= 8; k++) begin
      ts = (((ts * x) >> 30) * x >> 30) / ((2 * k) * (2 * k + 1));
      tc = (((tc * x) >> 30) * x >> 30) / ((2 * k - 1) * (2 * k));
      if (k & 1) begin
        ss -= ts; cc -= tc;
      end else begin
        ss += ts; cc += tc;
      end
    end
    sq = clamp(ss, 0, 1 << 30);
    cq = clamp(cc, 0, 1 << 30);
    case (quad)
      2'd0: begin sn = sq;  cs = cq;  end
      2'd1: begin sn = cq;  cs = -sq; end
      2'd2: begin sn = -sq; cs = -cq; end
      default: begin sn = -cq; cs = sq; end
    endcase
    w = (1 << 30) - cs;
    kx[0][0] = 0;     kx[0][1] = -u[2]; kx[0][2] = u[1];
    kx[1][0] = u[2];  kx[1][1] = 0;     kx[1][2] = -u[0];
    kx[2][0] = -u[1]; kx[2][1] = u[0];  kx[2][2] = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        e = (i == j) ? cs : 0;
        e += mul30(w, mul30(u[i], u[j]));
        e += mul30(sn, kx[i][j]);
        e = clamp(e, -(1 << 30), 1 << 30);
        mat[32*(3*i+j) +: 32] = e[31:0];
      end
    return mat;
  endfunction

  function void note_vector(input logic [95:0] vec);
    pending_q.push_back(rodrigues(vec));
  endfunction

  function void check_matrix(input logic [287:0] got);
    logic [287:0] exp_m;
    if (pending_q.size() == 0) begin
      $error("matrix beat with nothing pending: %h", got);
      errors++;
      return;
    end
    exp_m = pending_q.pop_front();
    for (int f = 0; f < 9; f++)
      if (got[32*f +: 32] !== exp_m[32*f +: 32]) begin
        $error("m%0d%0d expected %0d actual %0d", f / 3, f % 3,
               $signed(exp_m[32*f +: 32]), $signed(got[32*f +: 32]));
        errors++;
      end
  endfunction
endclass

module so3_exponential_map_core_tb;
  import so3em_pkg::*;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [287:0] m_tdata;

  rot_matrix_board board = new();
  int  send_idle_pct = 16;
  int  recv_idle_pct = 54;
  bit  hold_off = 0;
  bit  feed_done = 0;
  longint cycles = 0;

  localparam longint CYCLE_LIMIT = 400000;

  so3_exponential_map_core u_top (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: random stalls plus a long hold-off window
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_matrix(m_tdata);
    m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk)
    if (!rst && s_tvalid && s_tready) board.note_vector(s_tdata);

  task automatic send_vector(input logic [95:0] vec);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= vec;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      2: return 32'($signed($urandom_range(0, 1 << 28)) - (1 << 27));
      3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      4: return 32'($signed($urandom_range(0, 8)) - 4);
      default: return 32'($signed($urandom_range(0, 1 << 30)) - (1 << 29));
    endcase
  endfunction

  task automatic random_run(input int n);
    logic [31:0] c[3];
    for (int i = 0; i < n; i++) begin
      foreach (c[k]) c[k] = rand_comp();
      // sometimes zero one or two components (a single-axis rotation when two differ)
      if ($urandom_range(4) == 0) begin
        c[$urandom_range(2)] = 0;
        c[$urandom_range(2)] = 0;
      end
      send_vector({c[2], c[1], c[0]});
    end
  endtask

  initial begin
    logic [31:0] corner[8];
    corner = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h0C90_FDAA, 32'hF36F_0256, 32'h1921_FB54};
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // zero vector, single-axis extremes, quarter and half turns
    send_vector('0);
    for (int a = 0; a < 3; a++)
      for (int k = 1; k < 8; k++)
        if (a * 7 + k <= 22) send_vector(96'(corner[k]) << (32 * a));
    send_vector({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_vector({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    random_run(550);
    send_idle_pct = 54; recv_idle_pct = 16;
    random_run(550);
    send_idle_pct = 0; recv_idle_pct = 0;
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      random_run(400);
    join
    random_run(330);
    s_tvalid <= 0;
    feed_done = 1;
  end

  initial begin
    wait (feed_done);
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+src
src/so3em_pkg.sv
src/so3em_isqrt.sv
src/so3em_sincos.sv
src/so3_exponential_map_core.sv
bench/so3_exponential_map_core_tb.sv
